// ===== design/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and constants of the LIFO stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

	localparam int LSS_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int STS_W     = 2;
	localparam int POS_W     = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_NOP    = 3'd7;

	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY    = 2'd1;
	localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL     = 2'd3;

	typedef struct packed {
		logic accept;
		logic simple;
		logic rd_en;
		logic eval;
		logic finish;
	} lss_ctl_t;

	typedef struct packed {
		logic can_load;
		logic empty;
		logic eval_emit;
		logic walk_end;
		logic single;
		logic search;
	} lss_sts_t;

	function automatic logic cmd_walks(input logic [CMD_W-1:0] c);
		logic r;
		unique case (c) inside
			CMD_POP, CMD_PEEK, CMD_LIST, CMD_SEARCH: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl
// Command sequencer: accepts items and steps the datapath through a walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ctrl
	import lss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [CMD_W-1:0] command,
	output logic                  in_stall,
	output lss_ctl_t              ctl,
	input  wire lss_sts_t         st
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FINISH} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && st.can_load) begin
					ctl.accept = 1'b1;
					if (cmd_walks(command) && !st.empty) begin
						state_d = S_READ;
					end else if (command != CMD_NOP) begin
						ctl.simple = 1'b1;
					end
				end
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				if (!st.eval_emit || st.can_load) begin
					ctl.eval = 1'b1;
					if (st.single) begin
						state_d = S_IDLE;
					end else if (st.walk_end) begin
						state_d = st.search ? S_FINISH : S_IDLE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_FINISH: begin
				if (st.can_load) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = !((state_q == S_IDLE) && st.can_load);

endmodule

`default_nettype wire

// ===== design/lss_dpath.sv =====
// ----------------------------------------------------------------------------
// lss_dpath
// Entry memory, occupancy, walk pointer, search hold and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_dpath
	import lss_pkg::*;
#(
	parameter int STACK_DEPTH = LSS_DEPTH
)
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire lss_ctl_t                 ctl,
	output lss_sts_t                      st,
	input  wire logic                     out_stall,
	output logic                          out_valid,
	output logic [STS_W-1:0]              status,
	output logic signed [DATA_W-1:0]      element,
	output logic [POS_W-1:0]              position,
	output logic [POS_W-1:0]              occupancy,
	output logic                          last
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic signed [DATA_W-1:0] mem [STACK_DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_m1;
	logic [CW-1:0]            count_p1;
	logic [IW-1:0]            idx_q;
	logic [CW-1:0]            pos_q;
	logic [CMD_W-1:0]         cmd_q;
	logic signed [DATA_W-1:0] key_q;
	logic                     held_valid_q;
	logic [CW-1:0]            held_pos_q;

	logic                     full;
	logic                     match;
	logic                     do_write;

	logic                     out_valid_q;
	logic [STS_W-1:0]         status_q;
	logic signed [DATA_W-1:0] element_q;
	logic [POS_W-1:0]         position_q;
	logic [POS_W-1:0]         occupancy_q;
	logic                     last_q;

	logic                     ld;
	logic [STS_W-1:0]         ld_status;
	logic signed [DATA_W-1:0] ld_element;
	logic [CW-1:0]            ld_pos;
	logic [CW-1:0]            ld_occ;
	logic                     ld_last;
	logic [CW-1:0]            count_d;

	assign count_m1 = count_q - CW'(1);
	assign count_p1 = count_q + CW'(1);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign match    = (rd_data_q == key_q);
	assign do_write = ctl.simple && (command == CMD_PUSH) && !full;

	assign st.can_load  = !out_valid_q || !out_stall;
	assign st.empty     = (count_q == '0);
	assign st.search    = (cmd_q == CMD_SEARCH);
	assign st.single    = (cmd_q == CMD_POP) || (cmd_q == CMD_PEEK);
	assign st.walk_end  = (idx_q == '0);
	assign st.eval_emit = (cmd_q != CMD_SEARCH) || (match && held_valid_q);

	always_comb begin
		ld         = 1'b0;
		ld_status  = STS_OK;
		ld_element = '0;
		ld_pos     = '0;
		ld_occ     = count_q;
		ld_last    = 1'b1;
		count_d    = count_q;
		if (ctl.simple) begin
			ld = 1'b1;
			if (command == CMD_PUSH) begin
				if (full) begin
					ld_status = STS_FULL;
				end else begin
					ld_occ  = count_p1;
					count_d = count_p1;
				end
			end else if (command != CMD_COUNT) begin
				ld_occ  = '0;
				count_d = '0;
				if (count_q == '0) begin
					ld_status = STS_EMPTY;
				end
			end
		end else if (ctl.eval) begin
			ld = st.eval_emit;
			unique case (cmd_q)
				CMD_POP: begin
					ld_element = rd_data_q;
					ld_occ     = count_m1;
					count_d    = count_m1;
				end
				CMD_PEEK: begin
					ld_element = rd_data_q;
				end
				CMD_LIST: begin
					ld_element = rd_data_q;
					ld_pos     = pos_q;
					ld_last    = st.walk_end;
				end
				default: begin
					ld_element = key_q;
					ld_pos     = held_pos_q;
					ld_last    = 1'b0;
				end
			endcase
		end else if (ctl.finish) begin
			ld = 1'b1;
			if (held_valid_q) begin
				ld_element = key_q;
				ld_pos     = held_pos_q;
			end else begin
				ld_status = STS_NOTFOUND;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[count_q[IW-1:0]] <= value;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctl.accept) begin
				held_valid_q <= 1'b0;
			end else if (ctl.eval && st.search && match) begin
				held_valid_q <= 1'b1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= command;
			key_q <= value;
			idx_q <= count_m1[IW-1:0];
			pos_q <= CW'(1);
		end else if (ctl.eval) begin
			idx_q <= idx_q - IW'(1);
			pos_q <= pos_q + CW'(1);
			if (st.search && match) begin
				held_pos_q <= pos_q;
			end
		end
		if (ld) begin
			status_q    <= ld_status;
			element_q   <= ld_element;
			position_q  <= POS_W'(ld_pos);
			occupancy_q <= POS_W'(ld_occ);
			last_q      <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign position  = position_q;
	assign occupancy = occupancy_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== design/lifo_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed words with push, pop, peek, list, count,
// search and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: command and value, taken when in_valid is high and
//   in_stall is low. Result channel: status, element, position, occupancy
//   and last, taken when out_valid is high and out_stall is low. Every
//   command but code 7 yields one or more results; last marks the final one.
//   Sequence: push, count, clear and the empty, full cases load their result
//   register on acceptance. Pop and peek first do the memory read, then
//   evaluate. List and search read one entry at a time, newest first,
//   through the single registered memory read port, each read followed by
//   its evaluation; search gives one more result once the walk ends.
//   The next command is taken once the walk is done and the result register
//   is free. The result register holds while out_stall is high and the walk
//   waits on it; in_stall stays high meanwhile.
//   Reset empties the stack and drops any pending result; entry contents
//   are not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_search
	import lss_pkg::*;
#(
	parameter int STACK_DEPTH = LSS_DEPTH
)
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [CMD_W-1:0]         command,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [STS_W-1:0]              status,
	output logic signed [DATA_W-1:0]      element,
	output logic [POS_W-1:0]              position,
	output logic [POS_W-1:0]              occupancy,
	output logic                          last
);

	lss_ctl_t ctl;
	lss_sts_t st;

	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.ctl      (ctl),
		.st       (st)
	);

	lss_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.value     (value),
		.ctl       (ctl),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.element   (element),
		.position  (position),
		.occupancy (occupancy),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== design/lss_checker.sv =====
// ----------------------------------------------------------------------------
// lss_checker
// Port-level assertions for the LIFO stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_checker
	import lss_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_stall,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic [STS_W-1:0]         status,
	input wire logic signed [DATA_W-1:0] element,
	input wire logic [POS_W-1:0]         position,
	input wire logic [POS_W-1:0]         occupancy,
	input wire logic                     last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(last))
		else $error("stalled result changed");

	a_busy_mid_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("command accepted inside a multi-result walk");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_OK) |-> last && (position == '0) && (element == '0))
		else $error("error result not a lone final result");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.element   (element),
	.position  (position),
	.occupancy (occupancy),
	.last      (last)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the LIFO stack with search against a cycle-free stack predictor.
// A directed table walks the empty, full and extreme-value cases, then
// random command mixes with fill bursts run under random input gaps and
// result stalls. Every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench
	import lss_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [STS_W-1:0]         status;
		logic signed [DATA_W-1:0] element;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         occupancy;
		logic                     last;
	} stack_result_t;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] val;
		int                       reps;
		bit                       typed;
		logic [STS_W-1:0]         sts;
		logic signed [DATA_W-1:0] elem;
		logic [POS_W-1:0]         occ;
	} stim_row_t;

	localparam int N_DIR = 25;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;
	localparam logic signed [DATA_W-1:0] FILL_WORD = 32'sh5A5A5A5A;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic [STS_W-1:0]         status;
	logic signed [DATA_W-1:0] element;
	logic [POS_W-1:0]         position;
	logic [POS_W-1:0]         occupancy;
	logic                     last;

	stack_result_t            pending_results[$];
	logic signed [DATA_W-1:0] stack_mem [LSS_DEPTH];
	int                       depth_cnt;
	int                       errors;
	int                       in_gap_cap;
	int                       out_gap_cap;
	stim_row_t                dir_rows [N_DIR];

	lifo_stack_with_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.element   (element),
		.position  (position),
		.occupancy (occupancy),
		.last      (last)
	);

	always #6 clk = ~clk;

	function automatic void add_result(input logic [STS_W-1:0] sts,
			input logic signed [DATA_W-1:0] elem, input int pos, input int occ,
			input logic fin);
		stack_result_t r;
		r.status    = sts;
		r.element   = elem;
		r.position  = pos[POS_W-1:0];
		r.occupancy = occ[POS_W-1:0];
		r.last      = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_results(input logic [CMD_W-1:0] c,
			input logic signed [DATA_W-1:0] v);
		int hits;
		int n;
		hits = 0;
		n = depth_cnt;
		if (c == CMD_NOP)
			return;
		if (c == CMD_PUSH) begin
			if (n >= LSS_DEPTH) begin
				add_result(STS_FULL, '0, 0, n, 1'b1);
			end else begin
				stack_mem[n] = v;
				depth_cnt = n + 1;
				add_result(STS_OK, '0, 0, n + 1, 1'b1);
			end
			return;
		end
		if (c == CMD_COUNT) begin
			add_result(STS_OK, '0, 0, n, 1'b1);
			return;
		end
		if (n == 0) begin
			add_result(STS_EMPTY, '0, 0, 0, 1'b1);
			return;
		end
		case (c)
			CMD_POP: begin
				depth_cnt = n - 1;
				add_result(STS_OK, stack_mem[n-1], 0, n - 1, 1'b1);
			end
			CMD_PEEK: begin
				add_result(STS_OK, stack_mem[n-1], 0, n, 1'b1);
			end
			CMD_LIST: begin
				for (int i = 0; i < n; i++)
					add_result(STS_OK, stack_mem[n-1-i], i + 1, n, i + 1 == n);
			end
			CMD_SEARCH: begin
				for (int i = 0; i < n; i++) begin
					if (stack_mem[n-1-i] == v) begin
						add_result(STS_OK, v, i + 1, n, 1'b0);
						hits++;
					end
				end
				if (hits == 0)
					add_result(STS_NOTFOUND, '0, 0, n, 1'b1);
				else
					pending_results[pending_results.size()-1].last = 1'b1;
			end
			default: begin
				depth_cnt = 0;
				add_result(STS_OK, '0, 0, 0, 1'b1);
			end
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		logic signed [DATA_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = -1;
			2: w = WORD_MAX;
			3: w = WORD_MIN;
			4: w = $urandom_range(0, 3);
			5: w = FILL_WORD;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic int pick_cap();
		int c;
		case ($urandom_range(0, 2))
			0: c = 0;
			1: c = 4;
			default: c = 16;
		endcase
		return c;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
			input bit typed, input logic [STS_W-1:0] t_sts,
			input logic signed [DATA_W-1:0] t_elem, input logic [POS_W-1:0] t_occ);
		int gap;
		int queued;
		gap = $urandom_range(0, in_gap_cap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= c;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		queued = pending_results.size();
		predict_results(c, v);
		if (typed) begin
			while (pending_results.size() > queued)
				void'(pending_results.pop_back());
			add_result(t_sts, t_elem, 0, t_occ, 1'b1);
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d element %0d position %0d",
					status, element, position);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, status);
				compare_field("element", want.element, element);
				compare_field("position", want.position, position);
				compare_field("occupancy", want.occupancy, occupancy);
				compare_field("last", want.last, last);
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				n = $urandom_range(0, out_gap_cap);
				@(negedge clk);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int sent;
		int pick;
		int reps;
		int drain;
		logic [CMD_W-1:0] c;
		logic signed [DATA_W-1:0] v;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_COUNT;
		value       = '0;
		out_stall   = 1'b0;
		errors      = 0;
		depth_cnt   = 0;
		in_gap_cap  = 4;
		out_gap_cap = 4;

		dir_rows = '{
			'{CMD_POP,    '0,        1,  1'b1, STS_EMPTY,    '0,       5'd0},
			'{CMD_PEEK,   '0,        1,  1'b1, STS_EMPTY,    '0,       5'd0},
			'{CMD_LIST,   '0,        1,  1'b1, STS_EMPTY,    '0,       5'd0},
			'{CMD_SEARCH, '0,        1,  1'b1, STS_EMPTY,    '0,       5'd0},
			'{CMD_CLEAR,  '0,        1,  1'b1, STS_EMPTY,    '0,       5'd0},
			'{CMD_COUNT,  '0,        1,  1'b1, STS_OK,       '0,       5'd0},
			'{CMD_NOP,    '0,        1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_PUSH,   WORD_MAX,  1,  1'b1, STS_OK,       '0,       5'd1},
			'{CMD_PUSH,   WORD_MIN,  1,  1'b1, STS_OK,       '0,       5'd2},
			'{CMD_PUSH,   -1,        1,  1'b1, STS_OK,       '0,       5'd3},
			'{CMD_PUSH,   '0,        1,  1'b1, STS_OK,       '0,       5'd4},
			'{CMD_PUSH,   WORD_MIN,  1,  1'b1, STS_OK,       '0,       5'd5},
			'{CMD_PEEK,   '0,        1,  1'b1, STS_OK,       WORD_MIN, 5'd5},
			'{CMD_LIST,   '0,        1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_SEARCH, WORD_MIN,  1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_SEARCH, 12345,     1,  1'b1, STS_NOTFOUND, '0,       5'd5},
			'{CMD_NOP,    WORD_MAX,  1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_POP,    '0,        1,  1'b1, STS_OK,       WORD_MIN, 5'd4},
			'{CMD_COUNT,  '0,        1,  1'b1, STS_OK,       '0,       5'd4},
			'{CMD_CLEAR,  '0,        1,  1'b1, STS_OK,       '0,       5'd0},
			'{CMD_PUSH,   FILL_WORD, 16, 1'b0, STS_OK,       '0,       5'd0},
			'{CMD_PUSH,   1,         1,  1'b1, STS_FULL,     '0,       5'd16},
			'{CMD_SEARCH, FILL_WORD, 1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_LIST,   '0,        1,  1'b0, STS_OK,       '0,       5'd0},
			'{CMD_CLEAR,  '0,        1,  1'b1, STS_OK,       '0,       5'd0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_cmd(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed,
					dir_rows[i].sts, dir_rows[i].elem, dir_rows[i].occ);

		sent = 0;
		while (sent < 90) begin
			if ($urandom_range(0, 9) == 0) begin
				in_gap_cap  = pick_cap();
				out_gap_cap = pick_cap();
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				reps = $urandom_range(1, LSS_DEPTH + 1);
				repeat (reps)
					send_cmd(CMD_PUSH, rand_word(), 1'b0, STS_OK, '0, '0);
				sent += reps;
			end else begin
				v = rand_word();
				if (pick < 40)
					c = CMD_PUSH;
				else if (pick < 50)
					c = CMD_POP;
				else if (pick < 57)
					c = CMD_PEEK;
				else if (pick < 65)
					c = CMD_LIST;
				else if (pick < 72)
					c = CMD_COUNT;
				else if (pick < 88) begin
					c = CMD_SEARCH;
					if (depth_cnt > 0 && $urandom_range(0, 1) == 1)
						v = stack_mem[$urandom_range(0, depth_cnt - 1)];
				end else if (pick < 94)
					c = CMD_CLEAR;
				else
					c = CMD_NOP;
				send_cmd(c, v, 1'b0, STS_OK, '0, '0);
				if (c != CMD_NOP)
					sent++;
			end
		end
		in_valid <= 1'b0;

		drain = 0;
		while (pending_results.size() != 0 && drain < 200_000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);

		if (errors == 0 && pending_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d results never arrived", pending_results.size());
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
